/* hw/rtl/masked_correlation_normalizer_assert.svh */
// assertion macros for the masked correlation normalizer
`ifndef MASKED_CORRELATION_NORMALIZER_ASSERT_SVH
`define MASKED_CORRELATION_NORMALIZER_ASSERT_SVH

// same-cycle implication, checked out of reset
`define MCN_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("mcn check failed");

// next-cycle implication, checked out of reset
`define MCN_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("mcn check failed");

`endif

/* hw/rtl/mcn_pkg.sv */
// shared types and constants of the masked correlation normalizer
package mcn_pkg;

  localparam int unsigned IMAGE_DEPTH  = 16384;
  localparam int unsigned KERNEL_DEPTH = 2048;

  localparam int unsigned POS_W  = 14;
  localparam int unsigned LEN_W  = 15;
  localparam int unsigned KLEN_W = 12;
  localparam int unsigned CFG_W  = LEN_W;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned BYTE_W = 8;
  localparam int unsigned PIX_W  = 3 * BYTE_W;
  localparam int unsigned SEL_W  = 3;
  localparam int unsigned RES_W  = 5;
  localparam int unsigned IMG_AW = $clog2(IMAGE_DEPTH);
  localparam int unsigned KER_AW = $clog2(KERNEL_DEPTH);

  // divider sizes: dividend is sum * 31, divisor is the channel total plus one
  localparam int unsigned DVD_W  = BYTE_W + 5;
  localparam int unsigned DIVR_W = BYTE_W + 2;
  localparam int unsigned QUO_W  = RES_W;
  localparam int unsigned TRIAL_W = DIVR_W + QUO_W - 1;
  localparam int unsigned STEP_W = $clog2(QUO_W);

  localparam int unsigned NUM_CH = 3;
  localparam int unsigned CH_W   = $clog2(NUM_CH);
  localparam logic [CH_W-1:0] CH_LAST = CH_W'(NUM_CH - 1);

  localparam logic [LEN_W-1:0]  IMAGE_LEN_RST  = LEN_W'(16384);
  localparam logic [KLEN_W-1:0] KERNEL_LEN_RST = KLEN_W'(2048);

  localparam logic [1:0] OP_KERNEL    = 2'd0;
  localparam logic [1:0] OP_PIXEL     = 2'd1;
  localparam logic [1:0] OP_TRANSFORM = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_LEN  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_KERNEL_LEN = CFG_IDX_W'(1);

  typedef struct packed {
    logic [1:0]        operation;
    logic [POS_W-1:0]  position;
    logic              select_x;
    logic              select_y;
    logic              select_z;
    logic [BYTE_W-1:0] pixel_x;
    logic [BYTE_W-1:0] pixel_y;
    logic [BYTE_W-1:0] pixel_z;
  } in_item_t;

  typedef struct packed {
    logic [POS_W-1:0] result_position;
    logic [RES_W-1:0] result_x;
    logic [RES_W-1:0] result_y;
    logic [RES_W-1:0] result_z;
  } out_item_t;

  typedef struct packed {
    logic              pix_we;
    logic [IMG_AW-1:0] pix_waddr;
    logic [PIX_W-1:0]  pix_wdata;
    logic              ker_we;
    logic [KER_AW-1:0] ker_waddr;
    logic [SEL_W-1:0]  ker_wdata;
    logic              rd_en;
    logic [IMG_AW-1:0] pix_raddr;
    logic [KER_AW-1:0] ker_raddr;
  } store_cmd_t;

  typedef struct packed {
    logic              start;
    logic [DVD_W-1:0]  dividend;
    logic [DIVR_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [QUO_W-1:0] quotient;
  } div_rsp_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SETUP,
    S_WALK,
    S_DRAIN,
    S_DIV_START,
    S_DIV_WAIT,
    S_WRITE
  } state_t;

endpackage

/* hw/rtl/masked_correlation_normalizer.sv */
// masked correlation normalizer: sequencer, accumulators and result register
//
// Input channel in_valid/in_ready/in_data carries three kinds of item. A kernel
// write or a pixel write gives no result. A transform item at a position inside
// the image walks the window, one pixel and one kernel entry per cycle out of
// the stores, keeping three byte sums. The shared divider then normalizes each
// channel, and the result is written back to the pixel store and loaded into
// the output register. The window length is at most the kernel length (2048 at
// reset). A transform at or beyond the image length is dropped in its transfer
// cycle with no result.
// in_ready is high only while the sequencer is idle. The result waits in
// out_data under out_valid until out_ready; write items are still taken then,
// and a following transform holds its write-back until the register is free.
// Synchronous reset clears control state and sets image_length to 16384 and
// kernel_length to 2048; the stores are not cleared and must be written first.
// cfg_wr_en writes cfg_data into register cfg_index (0 image, 1 kernel length).
module masked_correlation_normalizer (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  mcn_pkg::in_item_t                 in_data,
  output logic                              out_valid,
  input  logic                              out_ready,
  output mcn_pkg::out_item_t                out_data,
  input  logic                              cfg_wr_en,
  input  logic [mcn_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [mcn_pkg::CFG_W-1:0]         cfg_data
);

  `include "masked_correlation_normalizer_assert.svh"

  mcn_pkg::state_t                 state_r;
  mcn_pkg::state_t                 state_nxt;
  logic [mcn_pkg::LEN_W-1:0]       image_length_r;
  logic [mcn_pkg::KLEN_W-1:0]      kernel_length_r;
  logic [mcn_pkg::POS_W-1:0]       pos_r;
  logic [mcn_pkg::LEN_W-1:0]       room_r;
  logic [mcn_pkg::KLEN_W-1:0]      span_r;
  logic [mcn_pkg::KLEN_W-1:0]      k_r;
  logic                            rd_vld_r;
  logic [mcn_pkg::BYTE_W-1:0]      sum_r [mcn_pkg::NUM_CH];
  logic [mcn_pkg::RES_W-1:0]       res_r [mcn_pkg::NUM_CH];
  logic [mcn_pkg::CH_W-1:0]        ch_r;
  logic                            out_valid_r;
  mcn_pkg::out_item_t              out_data_r;

  logic                            in_fire;
  logic [mcn_pkg::LEN_W-1:0]       len_eff;
  logic [mcn_pkg::LEN_W-1:0]       pos_ext;
  logic                            reject;
  logic [mcn_pkg::KLEN_W-1:0]      klen_eff;
  logic [mcn_pkg::KLEN_W-1:0]      span_nxt;
  logic                            issue;
  logic                            out_free;
  logic                            load_out;
  logic [mcn_pkg::DIVR_W-1:0]      total;
  logic [mcn_pkg::BYTE_W-1:0]      ch_sum;
  mcn_pkg::store_cmd_t             store_cmd;
  mcn_pkg::div_req_t               div_req;
  mcn_pkg::div_rsp_t               div_rsp;
  logic [mcn_pkg::PIX_W-1:0]       pix_rdata;
  logic [mcn_pkg::SEL_W-1:0]       ker_rdata;

  mcn_stores u_stores (
    .clk       (clk),
    .cmd       (store_cmd),
    .pix_rdata (pix_rdata),
    .ker_rdata (ker_rdata)
  );

  mcn_divider u_divider (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  // window bounds
  always_comb begin
    len_eff  = (image_length_r > mcn_pkg::LEN_W'(mcn_pkg::IMAGE_DEPTH)) ?
               mcn_pkg::LEN_W'(mcn_pkg::IMAGE_DEPTH) : image_length_r;
    pos_ext  = mcn_pkg::LEN_W'(in_data.position);
    reject   = pos_ext >= len_eff;
    klen_eff = (kernel_length_r > mcn_pkg::KLEN_W'(mcn_pkg::KERNEL_DEPTH)) ?
               mcn_pkg::KLEN_W'(mcn_pkg::KERNEL_DEPTH) : kernel_length_r;
    span_nxt = (mcn_pkg::LEN_W'(klen_eff) > room_r) ?
               mcn_pkg::KLEN_W'(room_r) : klen_eff;
    ch_sum   = sum_r[ch_r];
    total    = mcn_pkg::DIVR_W'(sum_r[0]) + mcn_pkg::DIVR_W'(sum_r[1]) +
               mcn_pkg::DIVR_W'(sum_r[2]) + mcn_pkg::DIVR_W'(1);
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      mcn_pkg::S_IDLE: begin
        if (in_fire && (in_data.operation == mcn_pkg::OP_TRANSFORM) && !reject) begin
          state_nxt = mcn_pkg::S_SETUP;
        end
      end
      mcn_pkg::S_SETUP: begin
        state_nxt = mcn_pkg::S_WALK;
      end
      mcn_pkg::S_WALK: begin
        if (k_r == span_r) begin
          state_nxt = mcn_pkg::S_DRAIN;
        end
      end
      mcn_pkg::S_DRAIN: begin
        state_nxt = mcn_pkg::S_DIV_START;
      end
      mcn_pkg::S_DIV_START: begin
        state_nxt = mcn_pkg::S_DIV_WAIT;
      end
      mcn_pkg::S_DIV_WAIT: begin
        if (div_rsp.done) begin
          state_nxt = (ch_r == mcn_pkg::CH_LAST) ? mcn_pkg::S_WRITE : mcn_pkg::S_DIV_START;
        end
      end
      mcn_pkg::S_WRITE: begin
        if (out_free) begin
          state_nxt = mcn_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = mcn_pkg::S_IDLE;
      end
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    in_ready  = (state_r == mcn_pkg::S_IDLE);
    in_fire   = in_valid && in_ready;
    issue     = (state_r == mcn_pkg::S_WALK) && (k_r != span_r);
    out_free  = !out_valid_r || out_ready;
    load_out  = (state_r == mcn_pkg::S_WRITE) && out_free;

    store_cmd.rd_en     = issue;
    store_cmd.pix_raddr = pos_r[mcn_pkg::IMG_AW-1:0] + mcn_pkg::IMG_AW'(k_r);
    store_cmd.ker_raddr = k_r[mcn_pkg::KER_AW-1:0];

    store_cmd.ker_we    = in_fire && (in_data.operation == mcn_pkg::OP_KERNEL) &&
                          (pos_ext < mcn_pkg::LEN_W'(mcn_pkg::KERNEL_DEPTH));
    store_cmd.ker_waddr = in_data.position[mcn_pkg::KER_AW-1:0];
    store_cmd.ker_wdata = {in_data.select_z, in_data.select_y, in_data.select_x};

    // pixel write item, or write-back of a finished transform
    if (load_out) begin
      store_cmd.pix_we    = 1'b1;
      store_cmd.pix_waddr = pos_r[mcn_pkg::IMG_AW-1:0];
      store_cmd.pix_wdata = {3'b000, res_r[2], 3'b000, res_r[1], 3'b000, res_r[0]};
    end else begin
      store_cmd.pix_we    = in_fire && (in_data.operation == mcn_pkg::OP_PIXEL) &&
                            (pos_ext < mcn_pkg::LEN_W'(mcn_pkg::IMAGE_DEPTH));
      store_cmd.pix_waddr = in_data.position[mcn_pkg::IMG_AW-1:0];
      store_cmd.pix_wdata = {in_data.pixel_z, in_data.pixel_y, in_data.pixel_x};
    end

    div_req.start    = (state_r == mcn_pkg::S_DIV_START);
    div_req.dividend = {ch_sum, 5'b00000} - mcn_pkg::DVD_W'(ch_sum);
    div_req.divisor  = total;
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= mcn_pkg::S_IDLE;
      rd_vld_r        <= 1'b0;
      out_valid_r     <= 1'b0;
      image_length_r  <= mcn_pkg::IMAGE_LEN_RST;
      kernel_length_r <= mcn_pkg::KERNEL_LEN_RST;
    end else begin
      state_r  <= state_nxt;
      rd_vld_r <= issue;
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_wr_en) begin
        case (cfg_index)
          mcn_pkg::CFG_IMAGE_LEN:  image_length_r  <= cfg_data;
          mcn_pkg::CFG_KERNEL_LEN: kernel_length_r <= cfg_data[mcn_pkg::KLEN_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (in_fire) begin
      pos_r  <= in_data.position;
      room_r <= len_eff - pos_ext;
    end
    if (state_r == mcn_pkg::S_SETUP) begin
      span_r <= span_nxt;
      k_r    <= '0;
      ch_r   <= '0;
      for (int c = 0; c < mcn_pkg::NUM_CH; c++) begin
        sum_r[c] <= '0;
      end
    end else begin
      if (issue) begin
        k_r <= k_r + mcn_pkg::KLEN_W'(1);
      end
      // modulo-256 sums of the selected channel bytes
      if (rd_vld_r) begin
        for (int c = 0; c < mcn_pkg::NUM_CH; c++) begin
          if (ker_rdata[c]) begin
            sum_r[c] <= sum_r[c] + pix_rdata[c*mcn_pkg::BYTE_W +: mcn_pkg::BYTE_W];
          end
        end
      end
      if ((state_r == mcn_pkg::S_DIV_WAIT) && div_rsp.done) begin
        res_r[ch_r] <= div_rsp.quotient;
        ch_r        <= ch_r + mcn_pkg::CH_W'(1);
      end
    end
    if (load_out) begin
      out_data_r.result_position <= pos_r;
      out_data_r.result_x        <= res_r[0];
      out_data_r.result_y        <= res_r[1];
      out_data_r.result_z        <= res_r[2];
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `MCN_ASSERT_NOW(a_div_done_in_wait, div_rsp.done, state_r == mcn_pkg::S_DIV_WAIT)
  `MCN_ASSERT_NOW(a_read_in_walk, rd_vld_r,
                  (state_r == mcn_pkg::S_WALK) || (state_r == mcn_pkg::S_DRAIN))
  `MCN_ASSERT_NOW(a_walk_in_span, state_r == mcn_pkg::S_WALK, k_r <= span_r)
  `MCN_ASSERT_NEXT(a_result_held, (state_r == mcn_pkg::S_WRITE) && out_valid_r && !out_ready,
                   state_r == mcn_pkg::S_WRITE)

endmodule

/* hw/rtl/mcn_divider.sv */
// restoring divider, one quotient bit per cycle, shared by the three channels
module mcn_divider (
  input  logic              clk,
  input  logic              rst_n,
  input  mcn_pkg::div_req_t req,
  output mcn_pkg::div_rsp_t rsp
);

  logic                              busy_r;
  logic                              done_r;
  logic [mcn_pkg::STEP_W-1:0]        step_r;
  logic [mcn_pkg::DVD_W-1:0]         rem_r;
  logic [mcn_pkg::DIVR_W-1:0]        div_r;
  logic [mcn_pkg::QUO_W-1:0]         quo_r;
  logic [mcn_pkg::TRIAL_W-1:0]       trial;
  logic                              fits;
  logic [mcn_pkg::DVD_W-1:0]         rem_nxt;
  logic [mcn_pkg::QUO_W-1:0]         quo_nxt;

  // divisor shifted to the current quotient bit
  always_comb begin
    trial   = mcn_pkg::TRIAL_W'(div_r) << step_r;
    fits    = mcn_pkg::TRIAL_W'(rem_r) >= trial;
    rem_nxt = fits ? (rem_r - mcn_pkg::DVD_W'(trial)) : rem_r;
    quo_nxt = quo_r | (mcn_pkg::QUO_W'(fits) << step_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= busy_r && (step_r == '0);
      if (req.start) begin
        busy_r <= 1'b1;
      end else if (busy_r && (step_r == '0)) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem_r  <= req.dividend;
      div_r  <= req.divisor;
      quo_r  <= '0;
      step_r <= mcn_pkg::STEP_W'(mcn_pkg::QUO_W - 1);
    end else if (busy_r) begin
      rem_r  <= rem_nxt;
      quo_r  <= quo_nxt;
      step_r <= step_r - mcn_pkg::STEP_W'(1);
    end
  end

  assign rsp.done     = done_r;
  assign rsp.quotient = quo_r;

endmodule

/* hw/rtl/mcn_stores.sv */
// pixel and kernel memories with registered read ports
module mcn_stores (
  input  logic                          clk,
  input  mcn_pkg::store_cmd_t           cmd,
  output logic [mcn_pkg::PIX_W-1:0]     pix_rdata,
  output logic [mcn_pkg::SEL_W-1:0]     ker_rdata
);

  logic [mcn_pkg::PIX_W-1:0] pix_mem [mcn_pkg::IMAGE_DEPTH];
  logic [mcn_pkg::SEL_W-1:0] ker_mem [mcn_pkg::KERNEL_DEPTH];
  logic [mcn_pkg::PIX_W-1:0] pix_rdata_r;
  logic [mcn_pkg::SEL_W-1:0] ker_rdata_r;

  always_ff @(posedge clk) begin
    if (cmd.pix_we) begin
      pix_mem[cmd.pix_waddr] <= cmd.pix_wdata;
    end
    if (cmd.rd_en) begin
      pix_rdata_r <= pix_mem[cmd.pix_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.ker_we) begin
      ker_mem[cmd.ker_waddr] <= cmd.ker_wdata;
    end
    if (cmd.rd_en) begin
      ker_rdata_r <= ker_mem[cmd.ker_raddr];
    end
  end

  assign pix_rdata = pix_rdata_r;
  assign ker_rdata = ker_rdata_r;

endmodule

/* tb/masked_correlation_normalizer_checker.sv */
// checker for the masked correlation normalizer: mirrors the stores, predicts and compares results
module masked_correlation_normalizer_checker (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  input  logic                              in_ready,
  input  mcn_pkg::in_item_t                 in_data,
  input  logic                              out_valid,
  input  logic                              out_ready,
  input  mcn_pkg::out_item_t                out_data,
  input  logic                              cfg_wr_en,
  input  logic [mcn_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [mcn_pkg::CFG_W-1:0]         cfg_data,
  output int                                fail_count,
  output int                                pending_count
);
  timeunit 1ns;
  timeprecision 1ps;

  import mcn_pkg::*;

  localparam int unsigned NORM_SCALE = 31;
  localparam int unsigned MAX_SHOWN  = 50;

  logic [PIX_W-1:0]  pixel_mem  [IMAGE_DEPTH];
  logic [SEL_W-1:0]  select_mem [KERNEL_DEPTH];
  logic [LEN_W-1:0]  image_len;
  logic [KLEN_W-1:0] kernel_len;
  out_item_t         normalized_q [$];
  out_item_t         oldest;

  initial begin
    fail_count = 0;
    pending_count = 0;
  end

  task automatic report_mismatch(string what, int unsigned got, int unsigned want);
    if (fail_count < MAX_SHOWN) begin
      $display("mismatch: %s got %0d expected %0d at %0t", what, got, want, $realtime);
    end
    fail_count++;
  endtask

  // updates the mirrored stores and queues the normalized pixel a transform produces
  task automatic correlate_item(in_item_t it);
    int unsigned       pos;
    int unsigned       eff;
    int unsigned       klim;
    int unsigned       span;
    int unsigned       total;
    logic [BYTE_W-1:0] sum_x;
    logic [BYTE_W-1:0] sum_y;
    logic [BYTE_W-1:0] sum_z;
    logic [PIX_W-1:0]  px;
    logic [SEL_W-1:0]  sel;
    out_item_t         res;
    pos = it.position;
    case (it.operation)
      OP_KERNEL: begin
        if (pos < KERNEL_DEPTH) select_mem[pos] = {it.select_z, it.select_y, it.select_x};
      end
      OP_PIXEL: begin
        pixel_mem[pos] = {it.pixel_z, it.pixel_y, it.pixel_x};
      end
      OP_TRANSFORM: begin
        eff = (image_len < IMAGE_DEPTH) ? image_len : IMAGE_DEPTH;
        if (pos < eff) begin
          klim = (kernel_len < KERNEL_DEPTH) ? kernel_len : KERNEL_DEPTH;
          span = (klim < eff - pos) ? klim : eff - pos;
          sum_x = '0;
          sum_y = '0;
          sum_z = '0;
          for (int unsigned k = 0; k < span; k++) begin
            px  = pixel_mem[pos + k];
            sel = select_mem[k];
            // byte sums wrap modulo 256
            if (sel[0]) sum_x += px[BYTE_W-1:0];
            if (sel[1]) sum_y += px[2*BYTE_W-1:BYTE_W];
            if (sel[2]) sum_z += px[PIX_W-1:2*BYTE_W];
          end
          total = sum_x + sum_y + sum_z + 1;
          res.result_position = it.position;
          res.result_x = RES_W'(sum_x * NORM_SCALE / total);
          res.result_y = RES_W'(sum_y * NORM_SCALE / total);
          res.result_z = RES_W'(sum_z * NORM_SCALE / total);
          // in-place write-back of the normalized pixel
          pixel_mem[pos] = {BYTE_W'(res.result_z), BYTE_W'(res.result_y),
                            BYTE_W'(res.result_x)};
          normalized_q.push_back(res);
        end
      end
      default: ;
    endcase
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      image_len  = IMAGE_LEN_RST;
      kernel_len = KERNEL_LEN_RST;
      normalized_q.delete();
    end else begin
      // a result transfer always stems from an earlier input transfer
      if (out_valid && out_ready) begin
        if (normalized_q.size() == 0) begin
          report_mismatch("unexpected result, position", out_data.result_position, 0);
        end else begin
          oldest = normalized_q.pop_front();
          if (out_data.result_position != oldest.result_position)
            report_mismatch("result_position", out_data.result_position,
                            oldest.result_position);
          if (out_data.result_x != oldest.result_x)
            report_mismatch("result_x", out_data.result_x, oldest.result_x);
          if (out_data.result_y != oldest.result_y)
            report_mismatch("result_y", out_data.result_y, oldest.result_y);
          if (out_data.result_z != oldest.result_z)
            report_mismatch("result_z", out_data.result_z, oldest.result_z);
        end
      end
      if (in_valid && in_ready) correlate_item(in_data);
      if (cfg_wr_en) begin
        case (cfg_index)
          CFG_IMAGE_LEN:  image_len  = cfg_data[LEN_W-1:0];
          CFG_KERNEL_LEN: kernel_len = cfg_data[KLEN_W-1:0];
          default: ;
        endcase
      end
    end
    pending_count = normalized_q.size();
  end

endmodule

/* tb/masked_correlation_normalizer_test.sv */
// top of the masked correlation normalizer testbench: clock, reset, stimulus and verdict
module masked_correlation_normalizer_test;
  timeunit 1ns;
  timeprecision 1ps;

  import mcn_pkg::*;

  localparam int unsigned CYCLE_LIMIT   = 1000000;
  localparam int unsigned HOLD_CYCLES   = 2000;
  localparam int unsigned SETTLE_CYCLES = 64;
  localparam int unsigned END_CYCLES    = 200;
  localparam logic [1:0]  OP_UNUSED     = 2'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = CFG_IDX_W'(3);

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_ready;
  in_item_t             in_data;
  logic                 out_valid;
  logic                 out_ready;
  out_item_t            out_data;
  logic                 cfg_wr_en;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_data;
  int                   fail_count;
  int                   pending_count;

  int unsigned cycle_count;
  bit          send_burst;
  bit          recv_burst;
  bit          hold_req;
  int unsigned img_len = 16384;
  int unsigned ker_len = 2048;
  int unsigned cfg_img;
  int unsigned cfg_klen;
  // which store entries hold defined data, so no transform reads garbage
  bit          pix_ok [IMAGE_DEPTH];
  bit          ker_ok [KERNEL_DEPTH];

  masked_correlation_normalizer u_top (.*);

  masked_correlation_normalizer_checker u_checker (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [BYTE_W-1:0] rand_byte();
    if ($urandom_range(0, 3) == 0) return $urandom_range(0, 1) ? 8'hff : 8'h00;
    return BYTE_W'($urandom);
  endfunction

  function automatic logic [PIX_W-1:0] random_pixel();
    return {rand_byte(), rand_byte(), rand_byte()};
  endfunction

  function automatic in_item_t make_item(logic [1:0] op, int unsigned pos);
    logic [63:0] noise;
    in_item_t    it;
    noise = {$urandom, $urandom};
    it = noise[$bits(in_item_t)-1:0];
    it.operation = op;
    it.position  = POS_W'(pos);
    return it;
  endfunction

  // window length of a transform under the current settings, -1 when rejected
  function automatic int window_span(int unsigned pos);
    int unsigned eff;
    int unsigned klim;
    eff = (img_len < IMAGE_DEPTH) ? img_len : IMAGE_DEPTH;
    if (pos >= eff) return -1;
    klim = (ker_len < KERNEL_DEPTH) ? ker_len : KERNEL_DEPTH;
    return (klim < eff - pos) ? klim : eff - pos;
  endfunction

  task automatic send_item(in_item_t it);
    int unsigned gap;
    gap = send_burst ? 0 : $urandom_range(0, 15);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic issue(in_item_t it);
    case (it.operation)
      OP_KERNEL: begin
        if (it.position < KERNEL_DEPTH) ker_ok[it.position] = 1'b1;
      end
      OP_PIXEL: pix_ok[it.position] = 1'b1;
      OP_TRANSFORM: begin
        if (window_span(it.position) >= 0) pix_ok[it.position] = 1'b1;
      end
      default: ;
    endcase
    send_item(it);
  endtask

  task automatic put_kernel(int unsigned pos, logic [SEL_W-1:0] sel);
    in_item_t it;
    it = make_item(OP_KERNEL, pos);
    {it.select_z, it.select_y, it.select_x} = sel;
    issue(it);
  endtask

  task automatic put_pixel(int unsigned pos, logic [PIX_W-1:0] px);
    in_item_t it;
    it = make_item(OP_PIXEL, pos);
    {it.pixel_z, it.pixel_y, it.pixel_x} = px;
    issue(it);
  endtask

  // loads whatever the window still lacks, then transforms
  task automatic transform_at(int unsigned pos);
    int span;
    span = window_span(pos);
    for (int k = 0; k < span; k++) begin
      if (!ker_ok[k]) put_kernel(k, SEL_W'($urandom));
      if (!pix_ok[pos + k]) put_pixel(pos + k, random_pixel());
    end
    issue(make_item(OP_TRANSFORM, pos));
  endtask

  task automatic configure(int unsigned img, int unsigned klen);
    in_valid <= 1'b0;
    do @(negedge clk); while (pending_count != 0);
    // writes and rejected transforms give no result, so let the block go idle
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= CFG_IMAGE_LEN;
    cfg_data  <= CFG_W'(img);
    @(posedge clk);
    cfg_index <= CFG_KERNEL_LEN;
    cfg_data  <= CFG_W'(klen);
    @(posedge clk);
    cfg_index <= $urandom_range(0, 1) ? CFG_SPARE_LO : CFG_SPARE_HI;
    cfg_data  <= CFG_W'($urandom);
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    img_len = img & 32'h7fff;
    ker_len = klen & 32'hfff;
  endtask

  task automatic random_segment(int unsigned count, int unsigned base, int unsigned width);
    int unsigned done;
    int unsigned pick;
    int unsigned pos;
    int unsigned kpos;
    int unsigned eff;
    done = 0;
    while (done < count) begin
      if ($urandom_range(0, 31) == 0) send_burst = !send_burst;
      pick = $urandom_range(0, 99);
      pos = base + $urandom_range(0, width - 1);
      if (pos > IMAGE_DEPTH - 1) pos = IMAGE_DEPTH - 1;
      eff = (img_len < IMAGE_DEPTH) ? img_len : IMAGE_DEPTH;
      if (pick < 20) begin
        kpos = ($urandom_range(0, 7) == 0) ? $urandom_range(0, IMAGE_DEPTH - 1)
                                           : $urandom_range(0, 31);
        put_kernel(kpos, SEL_W'($urandom));
        if (kpos < KERNEL_DEPTH) done++;
      end else if (pick < 50) begin
        put_pixel(pos, random_pixel());
        done++;
      end else if (pick < 90) begin
        transform_at(pos);
        done++;
      end else if (pick < 96) begin
        // positions past the image are rejected
        if (eff < IMAGE_DEPTH) transform_at($urandom_range(eff, IMAGE_DEPTH - 1));
        else transform_at(pos);
        done++;
      end else begin
        issue(make_item(OP_UNUSED, $urandom_range(0, IMAGE_DEPTH - 1)));
      end
    end
  endtask

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("masked_correlation_normalizer regression: fail");
    $finish;
  end

  // result side: random stalls, bursts, and one long hold-off on request
  initial begin
    int unsigned stall;
    out_ready <= 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (hold_req) begin
        out_ready <= 1'b0;
        for (int n = 0; n < HOLD_CYCLES; n++) @(posedge clk);
        hold_req = 1'b0;
      end
      if ($urandom_range(0, 31) == 0) recv_burst = !recv_burst;
      stall = recv_burst ? 0 : $urandom_range(0, 15);
      if (stall != 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  initial begin
    in_item_t junk;
    rst_n     <= 1'b0;
    in_valid  <= 1'b0;
    in_data   <= '0;
    cfg_wr_en <= 1'b0;
    cfg_index <= '0;
    cfg_data  <= '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // directed part under the reset lengths, windows at the top of the image
    put_kernel(0, 3'b111);
    put_kernel(1, 3'b000);
    put_kernel(2, 3'b101);
    put_kernel(3, 3'b010);
    put_kernel(KERNEL_DEPTH - 1, 3'b111);
    put_kernel(IMAGE_DEPTH - 1, 3'b111);
    put_pixel(IMAGE_DEPTH - 1, 24'hffffff);
    put_pixel(IMAGE_DEPTH - 2, 24'h000000);
    put_pixel(IMAGE_DEPTH - 3, 24'hff0180);
    put_pixel(IMAGE_DEPTH - 4, 24'h7f00ff);
    transform_at(IMAGE_DEPTH - 1);
    transform_at(IMAGE_DEPTH - 4);
    transform_at(IMAGE_DEPTH - 1);
    junk = '1;
    issue(junk);
    // single full channel gives the top result value
    put_kernel(0, 3'b001);
    put_pixel(IMAGE_DEPTH - 1, 24'hffffff);
    transform_at(IMAGE_DEPTH - 1);
    put_kernel(0, 3'b100);
    put_pixel(IMAGE_DEPTH - 1, 24'h00ff00);
    transform_at(IMAGE_DEPTH - 1);
    // sums wrap past 255
    put_kernel(0, 3'b111);
    put_kernel(1, 3'b111);
    put_kernel(2, 3'b111);
    put_pixel(IMAGE_DEPTH - 3, 24'hffffff);
    put_pixel(IMAGE_DEPTH - 2, 24'hffffff);
    put_pixel(IMAGE_DEPTH - 1, 24'hffffff);
    transform_at(IMAGE_DEPTH - 3);

    random_segment(20, IMAGE_DEPTH - 24, 24);

    configure(1, 1);
    transform_at(0);
    transform_at(1);
    transform_at(IMAGE_DEPTH - 1);
    random_segment(15, 0, 2);

    // kernel length above the depth, window cut by the image
    configure(24, 4095);
    random_segment(20, 0, 28);

    // image length above the depth and an empty kernel
    configure(32767, 0);
    random_segment(20, IMAGE_DEPTH - 24, 24);

    configure(300, 16);
    hold_req = 1'b1;
    random_segment(30, 268, 36);

    configure(16384, 2048);
    random_segment(20, IMAGE_DEPTH - 24, 24);

    cfg_img  = $urandom_range(1, IMAGE_DEPTH);
    cfg_klen = $urandom_range(1, 24);
    configure(cfg_img, cfg_klen);
    random_segment(20, (cfg_img > 24) ? cfg_img - 24 : 0, 28);

    in_valid <= 1'b0;
    do @(negedge clk); while (pending_count != 0);
    repeat (END_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending_count == 0) begin
      $display("masked_correlation_normalizer regression: pass");
    end else begin
      $display("masked_correlation_normalizer regression: fail");
    end
    $finish;
  end

endmodule

/* files.f */
+incdir+hw/rtl
hw/rtl/mcn_pkg.sv
hw/rtl/mcn_divider.sv
hw/rtl/mcn_stores.sv
hw/rtl/masked_correlation_normalizer.sv
tb/masked_correlation_normalizer_checker.sv
tb/masked_correlation_normalizer_test.sv
